@@ rtl/core/assd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package assd_pkg;

    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [15:0] POLL_PERIOD_RST = 16'd50;
    localparam logic [15:0] COOLDOWN_RST    = 16'd800;
    localparam logic [31:0] THRESHOLD_RST   = 32'd157000000;
    localparam logic [7:0]  COUNT_NEED_RST  = 8'd3;
    localparam logic [7:0]  NUM_SCREENS_RST = 8'd4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POLL_PERIOD = 3'd0,
        CFG_COOLDOWN    = 3'd1,
        CFG_THRESHOLD   = 3'd2,
        CFG_COUNT_NEED  = 3'd3,
        CFG_NUM_SCREENS = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [15:0] poll_period_ms;
        logic [15:0] cooldown_ms;
        logic [31:0] threshold_sq;
        logic [7:0]  count_needed;
        logic [7:0]  num_screens;
    } t_cfg;

    typedef struct packed {
        logic [7:0]  shake_count;
        logic        quiet_toggle;
        logic [31:0] last_poll_time;
        logic [31:0] last_advance_time;
        logic [7:0]  screen;
    } t_state;

endpackage
`default_nettype wire

@@ rtl/core/assd_step.sv @@
`timescale 1ns / 1ps
`default_nettype none
module assd_step
    import assd_pkg::*;
(
    input  wire t_cfg        i_cfg,
    input  wire t_state      i_state,
    input  wire logic [31:0] i_now_ms,
    input  wire logic        i_sensor_ok,
    input  wire logic        i_strong,
    output t_state           o_state,
    output logic             o_advanced
);

    logic [31:0] poll_diff;
    logic [31:0] adv_diff;
    logic        take;
    logic        in_cooldown;
    logic [7:0]  cnt_inc;
    logic [8:0]  scr_next;

    always_comb begin
        poll_diff   = i_now_ms - i_state.last_poll_time;
        adv_diff    = i_now_ms - i_state.last_advance_time;
        take        = i_sensor_ok && (poll_diff >= {16'd0, i_cfg.poll_period_ms});
        in_cooldown = adv_diff < {16'd0, i_cfg.cooldown_ms};
        cnt_inc     = (i_state.shake_count == 8'hFF) ? 8'hFF : i_state.shake_count + 8'd1;
        scr_next    = {1'b0, i_state.screen} + 9'd1;

        o_state    = i_state;
        o_advanced = 1'b0;
        if (take) begin
            o_state.last_poll_time = i_now_ms;
            if (in_cooldown) begin
                o_state.shake_count = 8'd0;
            end else if (i_strong) begin
                o_state.shake_count = cnt_inc;
                if (cnt_inc >= i_cfg.count_needed) begin
                    // wrap also catches an index left above a lowered screen count
                    o_state.screen = (scr_next >= {1'b0, i_cfg.num_screens}) ?
                                     8'd0 : scr_next[7:0];
                    o_state.last_advance_time = i_now_ms;
                    o_state.shake_count       = 8'd0;
                    o_advanced                = 1'b1;
                end
            end else if (i_state.quiet_toggle) begin
                o_state.quiet_toggle = 1'b0;
                if (i_state.shake_count != 8'd0) begin
                    o_state.shake_count = i_state.shake_count - 8'd1;
                end
            end else begin
                o_state.quiet_toggle = 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/accel_shake_screen_advance_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one item per cycle while the output is not stalled by i_out_ready; input register,
// square stage, sum/compare stage, then the state update loop, which is combinational from
// r_state back to r_state; its result is registered into the output register.
// Reset: i_rst_n synchronous, active low; clears stage valids, detector state,
// and loads the configuration registers with their defaults.
module accel_shake_screen_advance_core
    import assd_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,

    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [31:0]          i_cfg_data,

    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic [31:0]          i_now_ms,
    input  wire logic                 i_sensor_ok,
    input  wire logic signed [15:0]   i_accel_x,
    input  wire logic signed [15:0]   i_accel_y,
    input  wire logic signed [15:0]   i_accel_z,

    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic [7:0]                o_screen_index,
    output logic                      o_advanced
);

    function automatic logic [15:0] f_abs16(input logic [15:0] v);
        f_abs16 = v[15] ? (~v + 16'd1) : v;
    endfunction

    t_cfg        r_cfg;
    t_state      r_state;
    t_state      n_state;
    logic        n_adv;

    logic        r_v1, r_v2, r_v3, r_out_valid;
    logic [31:0] r_now1, r_now2, r_now3;
    logic        r_ok1, r_ok2, r_ok3;
    logic [15:0] r_ax, r_ay, r_az;
    logic [31:0] r_sqx, r_sqy, r_sqz;
    logic        r_strong;
    logic [7:0]  r_screen_out;
    logic        r_adv_out;

    logic        rdy_o, rdy3, rdy2, rdy1;
    logic        move3;
    logic [31:0] mag_sq;

    assign rdy_o = !r_out_valid || i_out_ready;
    assign rdy3  = !r_v3 || rdy_o;
    assign rdy2  = !r_v2 || rdy3;
    assign rdy1  = !r_v1 || rdy2;
    assign move3 = r_v3 && rdy_o;

    assign o_in_ready     = rdy1;
    assign o_cfg_ready    = 1'b1;
    assign o_out_valid    = r_out_valid;
    assign o_screen_index = r_screen_out;
    assign o_advanced     = r_adv_out;

    // squares are at most 2^30 each, so the sum fits in 32 bits
    assign mag_sq = r_sqx + r_sqy + r_sqz;

    assd_step u_step (
        .i_cfg       (r_cfg),
        .i_state     (r_state),
        .i_now_ms    (r_now3),
        .i_sensor_ok (r_ok3),
        .i_strong    (r_strong),
        .o_state     (n_state),
        .o_advanced  (n_adv)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.poll_period_ms <= POLL_PERIOD_RST;
            r_cfg.cooldown_ms    <= COOLDOWN_RST;
            r_cfg.threshold_sq   <= THRESHOLD_RST;
            r_cfg.count_needed   <= COUNT_NEED_RST;
            r_cfg.num_screens    <= NUM_SCREENS_RST;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_POLL_PERIOD: r_cfg.poll_period_ms <= i_cfg_data[15:0];
                CFG_COOLDOWN:    r_cfg.cooldown_ms    <= i_cfg_data[15:0];
                CFG_THRESHOLD:   r_cfg.threshold_sq   <= i_cfg_data;
                CFG_COUNT_NEED:  r_cfg.count_needed   <= i_cfg_data[7:0];
                CFG_NUM_SCREENS: r_cfg.num_screens    <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (rdy1) begin
                r_v1 <= i_in_valid;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
            if (rdy_o) begin
                r_out_valid <= r_v3;
            end
            if (move3) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1 && i_in_valid) begin
            r_now1 <= i_now_ms;
            r_ok1  <= i_sensor_ok;
            r_ax   <= f_abs16(i_accel_x);
            r_ay   <= f_abs16(i_accel_y);
            r_az   <= f_abs16(i_accel_z);
        end
        if (rdy2 && r_v1) begin
            r_now2 <= r_now1;
            r_ok2  <= r_ok1;
            r_sqx  <= 32'(r_ax) * 32'(r_ax);
            r_sqy  <= 32'(r_ay) * 32'(r_ay);
            r_sqz  <= 32'(r_az) * 32'(r_az);
        end
        if (rdy3 && r_v2) begin
            r_now3   <= r_now2;
            r_ok3    <= r_ok2;
            r_strong <= mag_sq > r_cfg.threshold_sq;
        end
        if (move3) begin
            r_screen_out <= n_state.screen;
            r_adv_out    <= n_adv;
        end
    end

`ifndef SYNTH
    // an advance always leaves the shake count cleared
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (move3 && n_adv) |=> (r_state.shake_count == 8'd0))
        else $error("shake count not cleared after advance");

    // a stalled result freezes the detector state
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> $stable(r_state))
        else $error("state moved while result stalled");

    // the new index stays within the screen count
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (move3 && n_adv) |=>
            (r_state.screen == 8'd0 || r_state.screen < r_cfg.num_screens))
        else $error("screen index out of range after advance");

    // the shown index tracks the state it was taken from
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        move3 |=> (r_screen_out == r_state.screen))
        else $error("result index differs from state");
`endif

endmodule
`default_nettype wire
